// ----- hdl/assert_macros.svh -----
// Assertion macros for the bond table checker.
// Expects signals clk and arst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted
`define MBT_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("mbt: assertion failed");

// Antecedent this cycle, consequent in the next cycle
`define MBT_ASSERT_NEXT(lbl, ante, cons) \
	`MBT_ASSERT(lbl, (ante) |=> (cons))

`endif

// ----- hdl/mbt_pkg.sv -----
// Shared types and constants of the MRU bond table.
// No dependencies; used by the interfaces, the cell, the top level and the checker.
package mbt_pkg;

	localparam int TABLE_DEPTH = 8;
	localparam int NAME_LIMIT  = 31;
	localparam int NAME_BYTES  = 32;
	localparam int CMD_W       = 3;
	localparam int ADDR_W      = 48;
	localparam int NAME_W      = 8 * NAME_BYTES;
	localparam int PAY_W       = 144;
	localparam int CNT_W       = 4;

	// Command codes; codes above CMD_FIND do nothing
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_UPSERT = 3'd1;
	localparam logic [CMD_W-1:0] CMD_TOUCH  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_ERASE  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_FIND   = 3'd4;

	// One table slot
	typedef struct packed {
		logic              valid;
		logic [ADDR_W-1:0] addr;
		logic [NAME_W-1:0] name;
		logic [PAY_W-1:0]  payload;
	} entry_t;

	// Control broadcast from the sequencer to every cell
	typedef struct packed {
		logic             capture;  // lookup cycle: latch compare results
		logic             apply;    // update cycle: move entries
		logic [CMD_W-1:0] cmd;
		logic             hit;      // key present somewhere in the table
	} cell_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_UPD
	} state_t;

endpackage

// ----- hdl/mbt_if.sv -----
// Valid/ready channel interfaces for command and response transfers.
// Depends on mbt_pkg for field widths.
interface mbt_in_if;
	logic                         valid;
	logic                         ready;
	logic [mbt_pkg::CMD_W-1:0]    command;
	logic [mbt_pkg::ADDR_W-1:0]   address;
	logic [63:0]                  name_w0;
	logic [63:0]                  name_w1;
	logic [63:0]                  name_w2;
	logic [63:0]                  name_w3;
	logic [63:0]                  payload_w0;
	logic [63:0]                  payload_w1;
	logic [15:0]                  payload_w2;

	modport source (output valid, command, address, name_w0, name_w1, name_w2, name_w3,
		payload_w0, payload_w1, payload_w2, input ready);
	modport sink (input valid, command, address, name_w0, name_w1, name_w2, name_w3,
		payload_w0, payload_w1, payload_w2, output ready);
endinterface

interface mbt_out_if;
	logic                       valid;
	logic                       ready;
	logic                       found;
	logic [63:0]                out_name_w0;
	logic [63:0]                out_name_w1;
	logic [63:0]                out_name_w2;
	logic [63:0]                out_name_w3;
	logic [63:0]                out_payload_w0;
	logic [63:0]                out_payload_w1;
	logic [15:0]                out_payload_w2;
	logic [mbt_pkg::CNT_W-1:0]  entry_count;
	logic                       modified;

	modport source (output valid, found, out_name_w0, out_name_w1, out_name_w2, out_name_w3,
		out_payload_w0, out_payload_w1, out_payload_w2, entry_count, modified, input ready);
	modport sink (input valid, found, out_name_w0, out_name_w1, out_name_w2, out_name_w3,
		out_payload_w0, out_payload_w1, out_payload_w2, entry_count, modified, output ready);
endinterface

// ----- hdl/mbt_cell.sv -----
// One slot of the MRU chain: holds an entry, compares it to the key and
// takes its left or right neighbor on update. Depends on mbt_pkg.
module mbt_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mbt_pkg::cell_ctl_t         ctl,
	input  logic [mbt_pkg::ADDR_W-1:0] key,
	input  logic                       before_in,
	input  mbt_pkg::entry_t            sel_in,
	input  mbt_pkg::entry_t            left,
	input  mbt_pkg::entry_t            right,
	output logic                       before_out,
	output mbt_pkg::entry_t            sel_out,
	output mbt_pkg::entry_t            entry
);

	mbt_pkg::entry_t entry_q;
	logic            match;
	logic            match_s2;
	logic            before_s2;

	// Key compare and the hit / matched-entry chains
	assign match      = entry_q.valid && (entry_q.addr == key);
	assign before_out = before_in | match;
	assign sel_out    = sel_in | (match ? entry_q : '0);
	assign entry      = entry_q;

	// Latch where this cell sits relative to the hit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_s2  <= 1'b0;
			before_s2 <= 1'b0;
		end else if (ctl.capture) begin
			match_s2  <= match;
			before_s2 <= before_in;
		end
	end

	// Slot update: clear on clear, shift toward the back on insert/move, toward the front on erase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (ctl.apply) begin
			case (ctl.cmd)
				mbt_pkg::CMD_CLEAR: begin
					entry_q <= '0;
				end
				mbt_pkg::CMD_UPSERT: begin
					if (!before_s2) entry_q <= left;
				end
				mbt_pkg::CMD_TOUCH: begin
					if (ctl.hit && !before_s2) entry_q <= left;
				end
				mbt_pkg::CMD_ERASE: begin
					if (ctl.hit && (before_s2 || match_s2)) entry_q <= right;
				end
				default: begin
					entry_q <= entry_q;
				end
			endcase
		end
	end

endmodule

// ----- hdl/mru_bond_table_core.sv -----
// Top level of the MRU bond table: sequencer, input/result registers and the cell chain.
// Depends on mbt_pkg, mbt_if (mbt_in_if, mbt_out_if) and mbt_cell.
//
//   channel  dir  handshake         contents
//   req      in   valid/ready       command, address, name, payload
//   rsp      out  valid/ready       found, name, payload, entry_count, modified
//
// Each command has a lookup cycle (all cells compare the key in parallel) and
// an update cycle (each cell that moves loads from a neighbor at once).
// A new command is taken while idle or in the update cycle of the previous one,
// when the result register is free. Reset clears all slots at once; no clearing pass.
// A stalled response holds the update cycle until the result register frees.
module mru_bond_table_core (
	input  logic      clk,
	input  logic      arst_n,
	mbt_in_if.sink    req,
	mbt_out_if.source rsp
);

	localparam int D = mbt_pkg::TABLE_DEPTH;

	mbt_pkg::state_t           state_q, state_nxt;
	logic                      accept;
	logic                      out_free;
	logic                      capture;
	logic                      apply;

	// Stage 1: accepted command
	logic [mbt_pkg::CMD_W-1:0]  cmd_s1;
	logic [mbt_pkg::ADDR_W-1:0] addr_s1;
	logic [mbt_pkg::NAME_W-1:0] name_s1;
	logic [mbt_pkg::PAY_W-1:0]  pay_s1;
	logic [mbt_pkg::NAME_W-1:0] raw_name;
	logic [mbt_pkg::NAME_W-1:0] norm_name;

	// Stage 2: lookup results
	logic [mbt_pkg::CMD_W-1:0]  cmd_s2;
	logic                       hit_s2;
	logic                       at_front_s2;
	mbt_pkg::entry_t            front_s2;
	mbt_pkg::entry_t            front_c;

	// Chain links
	logic                       before_c [D+1];
	mbt_pkg::entry_t            sel_c    [D+1];
	mbt_pkg::entry_t            slot_c   [D];
	mbt_pkg::cell_ctl_t         ctl;

	// Table status
	logic [mbt_pkg::CNT_W-1:0]  count_q, count_nxt;
	logic                       dirty_q, dirty_nxt;
	logic                       found_c;

	// Result register
	logic                       rsp_valid_q;
	logic                       found_q;
	logic [mbt_pkg::NAME_W-1:0] rname_q;
	logic [mbt_pkg::PAY_W-1:0]  rpay_q;

	// Handshake
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == mbt_pkg::ST_IDLE) ||
		((state_q == mbt_pkg::ST_UPD) && out_free);
	assign accept    = req.valid && req.ready;
	assign capture   = (state_q == mbt_pkg::ST_LOOK);
	assign apply     = (state_q == mbt_pkg::ST_UPD) && out_free;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= mbt_pkg::ST_IDLE;
		else         state_q <= state_nxt;
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			mbt_pkg::ST_IDLE: begin
				if (accept) state_nxt = mbt_pkg::ST_LOOK;
			end
			mbt_pkg::ST_LOOK: begin
				state_nxt = mbt_pkg::ST_UPD;
			end
			mbt_pkg::ST_UPD: begin
				if (out_free) state_nxt = accept ? mbt_pkg::ST_LOOK : mbt_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = mbt_pkg::ST_IDLE;
			end
		endcase
	end

	// Name cut at the first zero byte or the name limit, zero-filled
	assign raw_name = {req.name_w3, req.name_w2, req.name_w1, req.name_w0};

	always_comb begin
		logic keep;
		keep = 1'b1;
		for (int n = 0; n < mbt_pkg::NAME_BYTES; n++) begin
			keep = keep && (n < mbt_pkg::NAME_LIMIT) && (raw_name[8*n +: 8] != 8'd0);
			norm_name[8*n +: 8] = keep ? raw_name[8*n +: 8] : 8'd0;
		end
	end

	// Stage 1 capture
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= req.command;
			addr_s1 <= req.address;
			name_s1 <= norm_name;
			pay_s1  <= {req.payload_w2, req.payload_w1, req.payload_w0};
		end
	end

	// Entry that goes to the front: new bond for upsert, else the matched one
	always_comb begin
		front_c = sel_c[D];
		if (cmd_s1 == mbt_pkg::CMD_UPSERT) begin
			front_c.valid   = 1'b1;
			front_c.addr    = addr_s1;
			front_c.payload = pay_s1;
			front_c.name    = (before_c[D] && (name_s1[7:0] == 8'd0)) ?
				sel_c[D].name : name_s1;
		end
	end

	// Stage 2 capture
	always_ff @(posedge clk) begin
		if (capture) begin
			cmd_s2      <= cmd_s1;
			hit_s2      <= before_c[D];
			at_front_s2 <= before_c[1];
			front_s2    <= front_c;
		end
	end

	// Cell chain
	assign ctl.capture = capture;
	assign ctl.apply   = apply;
	assign ctl.cmd     = cmd_s2;
	assign ctl.hit     = hit_s2;
	assign before_c[0] = 1'b0;
	assign sel_c[0]    = '0;

	for (genvar k = 0; k < D; k++) begin : g_cell
		mbt_pkg::entry_t left_c;
		mbt_pkg::entry_t right_c;
		if (k == 0) begin : g_head
			assign left_c = front_s2;
		end else begin : g_body
			assign left_c = slot_c[k-1];
		end
		if (k == D - 1) begin : g_tail
			assign right_c = '0;
		end else begin : g_mid
			assign right_c = slot_c[k+1];
		end

		mbt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.key        (addr_s1),
			.before_in  (before_c[k]),
			.sel_in     (sel_c[k]),
			.left       (left_c),
			.right      (right_c),
			.before_out (before_c[k+1]),
			.sel_out    (sel_c[k+1]),
			.entry      (slot_c[k])
		);
	end

	// Count, dirty mark and found flag after the command
	always_comb begin
		count_nxt = count_q;
		dirty_nxt = dirty_q;
		found_c   = 1'b0;
		case (cmd_s2)
			mbt_pkg::CMD_CLEAR: begin
				count_nxt = '0;
				dirty_nxt = 1'b1;
			end
			mbt_pkg::CMD_UPSERT: begin
				found_c   = hit_s2;
				dirty_nxt = 1'b1;
				if (!hit_s2 && (count_q < mbt_pkg::CNT_W'(D))) count_nxt = count_q + 1'b1;
			end
			mbt_pkg::CMD_TOUCH: begin
				found_c = hit_s2;
				if (hit_s2 && !at_front_s2) dirty_nxt = 1'b1;
			end
			mbt_pkg::CMD_ERASE: begin
				found_c = hit_s2;
				if (hit_s2) begin
					count_nxt = count_q - 1'b1;
					dirty_nxt = 1'b1;
				end
			end
			mbt_pkg::CMD_FIND: begin
				found_c = hit_s2;
			end
			default: begin
				found_c = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			dirty_q <= 1'b0;
		end else if (apply) begin
			count_q <= count_nxt;
			dirty_q <= dirty_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			found_q     <= 1'b0;
			rname_q     <= '0;
			rpay_q      <= '0;
		end else if (apply) begin
			rsp_valid_q <= 1'b1;
			found_q     <= found_c;
			if ((cmd_s2 == mbt_pkg::CMD_FIND) && hit_s2) begin
				rname_q <= front_s2.name;
				rpay_q  <= front_s2.payload;
			end else begin
				rname_q <= '0;
				rpay_q  <= '0;
			end
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.found          = found_q;
	assign rsp.out_name_w0    = rname_q[63:0];
	assign rsp.out_name_w1    = rname_q[127:64];
	assign rsp.out_name_w2    = rname_q[191:128];
	assign rsp.out_name_w3    = rname_q[255:192];
	assign rsp.out_payload_w0 = rpay_q[63:0];
	assign rsp.out_payload_w1 = rpay_q[127:64];
	assign rsp.out_payload_w2 = rpay_q[143:128];
	assign rsp.entry_count    = count_q;
	assign rsp.modified       = dirty_q;

endmodule

// ----- hdl/mbt_checker.sv -----
// Port-level checks for the MRU bond table, bound onto the top level.
// Depends on mbt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mbt_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic                       found,
	input logic [399:0]               out_data,
	input logic [mbt_pkg::CNT_W-1:0]  entry_count,
	input logic                       modified
);

	// A stalled response keeps its contents
	`MBT_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(out_data) && $stable(found) && $stable(entry_count))

	// Count never exceeds the table depth
	`MBT_ASSERT(a_count_bound, out_valid |-> (entry_count <= mbt_pkg::CNT_W'(mbt_pkg::TABLE_DEPTH)))

	// Entry data only accompanies a hit
	`MBT_ASSERT(a_data_on_hit, (out_valid && !found) |-> (out_data == '0))

	// The dirty mark never drops once set
	`MBT_ASSERT_NEXT(a_dirty_sticky, out_valid && modified, modified)

endmodule

bind mru_bond_table_core mbt_checker u_mbt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (rsp.valid),
	.out_ready   (rsp.ready),
	.found       (rsp.found),
	.out_data    ({rsp.out_payload_w2, rsp.out_payload_w1, rsp.out_payload_w0,
		rsp.out_name_w3, rsp.out_name_w2, rsp.out_name_w1, rsp.out_name_w0}),
	.entry_count (rsp.entry_count),
	.modified    (rsp.modified)
);
